/* hw/rtl/miu_pkg.sv */
// ----------------------------------------------------------------------------
// Integer execute unit package
// Operation codes, controller command/status types and shared widths and types.
// ----------------------------------------------------------------------------
package miu_pkg;

    localparam int WordWidth = 32;
    localparam int CountWidth = 6;

    typedef logic [WordWidth-1:0] word_t;

    // Operation codes.
    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_SUB   = 5'd1;
    localparam logic [4:0] OP_AND   = 5'd2;
    localparam logic [4:0] OP_OR    = 5'd3;
    localparam logic [4:0] OP_XOR   = 5'd4;
    localparam logic [4:0] OP_NOR   = 5'd5;
    localparam logic [4:0] OP_ADDI  = 5'd6;
    localparam logic [4:0] OP_ADDIU = 5'd7;
    localparam logic [4:0] OP_ANDI  = 5'd8;
    localparam logic [4:0] OP_ORI   = 5'd9;
    localparam logic [4:0] OP_XORI  = 5'd10;
    localparam logic [4:0] OP_LUI   = 5'd11;
    localparam logic [4:0] OP_SLT   = 5'd12;
    localparam logic [4:0] OP_SLTI  = 5'd13;
    localparam logic [4:0] OP_SLTIU = 5'd14;
    localparam logic [4:0] OP_SLL   = 5'd15;
    localparam logic [4:0] OP_SRL   = 5'd16;
    localparam logic [4:0] OP_SRA   = 5'd17;
    localparam logic [4:0] OP_MULT  = 5'd18;
    localparam logic [4:0] OP_DIV   = 5'd19;
    localparam logic [4:0] OP_MFHI  = 5'd20;
    localparam logic [4:0] OP_MFLO  = 5'd21;
    localparam logic [4:0] OP_BEQ   = 5'd22;
    localparam logic [4:0] OP_BNE   = 5'd23;
    localparam logic [4:0] OP_BGEZ  = 5'd24;
    localparam logic [4:0] OP_BLEZ  = 5'd25;
    localparam logic [4:0] OP_J     = 5'd26;
    localparam logic [4:0] OP_JAL   = 5'd27;
    localparam logic [4:0] OP_JR    = 5'd28;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture input word and the combinational result
        logic mul_store;  // write the registered product into HI and LO
        logic div_start;  // load the divider registers
        logic div_step;   // one restoring divide step
        logic div_store;  // write quotient and remainder into HI and LO
    } miu_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_mult;
        logic is_div;
        logic div_zero;
        logic div_last;
    } miu_status_t;

endpackage

/* hw/rtl/miu_if.sv */
// ----------------------------------------------------------------------------
// Execute unit channels
// Valid/ready interfaces for the instruction and result words.
// ----------------------------------------------------------------------------
interface miu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  operation;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [25:0] jump_index;
    logic [31:0] current_pc;

    modport source (output valid, operation, operand_a, operand_b, immediate,
                    shift_amount, jump_index, current_pc, input ready);
    modport sink (input valid, operation, operand_a, operand_b, immediate,
                  shift_amount, jump_index, current_pc, output ready);
endinterface

interface miu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        write_result;
    logic [31:0] next_pc;
    logic        branch_taken;
    logic        divide_by_zero;

    modport source (output valid, result, write_result, next_pc, branch_taken,
                    divide_by_zero, input ready);
    modport sink (input valid, result, write_result, next_pc, branch_taken,
                  divide_by_zero, output ready);
endinterface

/* hw/rtl/miu_datapath.sv */
// ----------------------------------------------------------------------------
// Execute unit datapath
// ALU, branch logic, registered multiplier, serial divider and HI/LO.
// ----------------------------------------------------------------------------
module miu_datapath
    import miu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  miu_cmd_t    cmd,
    output miu_status_t status,
    input  logic [4:0]  operation,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [15:0] immediate,
    input  logic [4:0]  shift_amount,
    input  logic [25:0] jump_index,
    input  logic [31:0] current_pc,
    output logic [31:0] result,
    output logic        write_result,
    output logic [31:0] next_pc,
    output logic        branch_taken,
    output logic        divide_by_zero
);

    word_t high_reg, high_next, low_reg, low_next;
    logic [4:0] op_reg;
    word_t a_reg, b_reg;
    word_t res_reg, res_next, npc_reg, npc_next;
    logic wr_reg, wr_next, tk_reg, tk_next;
    logic [63:0] prod_reg;
    word_t quo_reg, quo_next, rem_reg, rem_next, dsr_reg;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    logic neg_q_reg, neg_r_reg;

    word_t sext_imm, zext_imm, btarget, jtarget;
    logic cond;
    logic [32:0] trial;

    assign sext_imm = {{16{immediate[15]}}, immediate};
    assign zext_imm = {16'd0, immediate};
    assign btarget  = current_pc + {sext_imm[29:0], 2'b00};
    assign jtarget  = {current_pc[31:28], jump_index, 2'b00};

    // Combinational result, write flag and next PC.
    always_comb
    begin
        res_next = '0;
        wr_next  = 1'b1;
        tk_next  = 1'b0;
        npc_next = current_pc;
        cond     = 1'b0;
        unique case (operation) inside
            OP_ADD:   res_next = operand_a + operand_b;
            OP_SUB:   res_next = operand_a - operand_b;
            OP_AND:   res_next = operand_a & operand_b;
            OP_OR:    res_next = operand_a | operand_b;
            OP_XOR:   res_next = operand_a ^ operand_b;
            OP_NOR:   res_next = ~(operand_a | operand_b);
            OP_ADDI, OP_ADDIU: res_next = operand_a + sext_imm;
            OP_ANDI:  res_next = operand_a & zext_imm;
            OP_ORI:   res_next = operand_a | zext_imm;
            OP_XORI:  res_next = operand_a ^ zext_imm;
            OP_LUI:   res_next = {immediate, 16'd0};
            OP_SLT:   res_next = {31'd0, $signed(operand_a) < $signed(operand_b)};
            OP_SLTI:  res_next = {31'd0, $signed(operand_a) < $signed(sext_imm)};
            OP_SLTIU: res_next = {31'd0, operand_a < sext_imm};
            OP_SLL:   res_next = operand_b << shift_amount;
            OP_SRL:   res_next = operand_b >> shift_amount;
            OP_SRA:   res_next = word_t'($signed(operand_b) >>> shift_amount);
            OP_MFHI:  res_next = high_reg;
            OP_MFLO:  res_next = low_reg;
            OP_BEQ:   begin wr_next = 1'b0; cond = operand_a == operand_b; end
            OP_BNE:   begin wr_next = 1'b0; cond = operand_a != operand_b; end
            OP_BGEZ:  begin wr_next = 1'b0; cond = !operand_a[31]; end
            OP_BLEZ:
            begin
                wr_next = 1'b0;
                cond = operand_a[31] || (operand_a == '0);
            end
            OP_J:     begin wr_next = 1'b0; tk_next = 1'b1; npc_next = jtarget; end
            OP_JAL:   begin res_next = current_pc; tk_next = 1'b1; npc_next = jtarget; end
            OP_JR:    begin wr_next = 1'b0; tk_next = 1'b1; npc_next = operand_a; end
            default:  wr_next = 1'b0;
        endcase
        if (cond)
        begin
            tk_next  = 1'b1;
            npc_next = btarget;
        end
    end

    // Restoring divide step on magnitudes.
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            quo_next = a_reg[31] ? -a_reg : a_reg;
            rem_next = '0;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[32])
                rem_next = trial[31:0];
            else
                rem_next = {rem_reg[30:0], quo_reg[31]};
            quo_next = {quo_reg[30:0], !trial[32]};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // HI and LO update.
    always_comb
    begin
        high_next = high_reg;
        low_next  = low_reg;
        if (cmd.mul_store)
        begin
            high_next = prod_reg[63:32];
            low_next  = prod_reg[31:0];
        end
        else if (cmd.div_store)
        begin
            high_next = neg_r_reg ? -rem_reg : rem_reg;
            low_next  = neg_q_reg ? -quo_reg : quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= '0;
            low_reg  <= '0;
        end
        else
        begin
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
            res_reg <= res_next;
            wr_reg  <= wr_next;
            tk_reg  <= tk_next;
            npc_reg <= npc_next;
        end
        if (cmd.div_start)
        begin
            dsr_reg   <= b_reg[31] ? -b_reg : b_reg;
            neg_q_reg <= a_reg[31] ^ b_reg[31];
            neg_r_reg <= a_reg[31];
        end
        prod_reg <= 64'($signed(a_reg) * $signed(b_reg));
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign status.is_mult  = op_reg == OP_MULT;
    assign status.is_div   = op_reg == OP_DIV;
    assign status.div_zero = b_reg == '0;
    assign status.div_last = cnt_reg == CountWidth'(WordWidth - 1);

    assign result         = res_reg;
    assign write_result   = wr_reg;
    assign next_pc        = npc_reg;
    assign branch_taken   = tk_reg;
    assign divide_by_zero = (op_reg == OP_DIV) && (b_reg == '0);

endmodule

/* hw/rtl/miu_control.sv */
// ----------------------------------------------------------------------------
// Execute unit controller
// Sequences accept, multiply, divide steps and result hand-off.
// ----------------------------------------------------------------------------
module miu_control
    import miu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output miu_cmd_t    cmd,
    input  miu_status_t status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (status.is_mult)
                    state_next = S_MUL;
                else if (status.is_div && !status.div_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_OUT;
            end
            S_MUL:
            begin
                cmd.mul_store = 1'b1;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_DST;
            end
            S_DST:
            begin
                cmd.div_store = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hw/rtl/mips_integer_execute_unit_top.sv */
// Sequence: after accept, ALU, branch, HI/LO moves and div by zero pass through
// decode to the output state; mult adds a HI/LO store, and div adds the serial
// divide steps (32 serial quotient bits) and a HI/LO store. Throughput: one word
// at a time; a new word can be taken the cycle after the result is taken.
// Reset clears the controller and HI/LO to zero.
// ----------------------------------------------------------------------------
// MIPS32 integer execute unit
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_top
    import miu_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    miu_in_if.sink   in_ch,
    miu_out_if.source out_ch
);

    miu_cmd_t    cmd;
    miu_status_t status;

    miu_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    miu_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (in_ch.operation),
        .operand_a      (in_ch.operand_a),
        .operand_b      (in_ch.operand_b),
        .immediate      (in_ch.immediate),
        .shift_amount   (in_ch.shift_amount),
        .jump_index     (in_ch.jump_index),
        .current_pc     (in_ch.current_pc),
        .result         (out_ch.result),
        .write_result   (out_ch.write_result),
        .next_pc        (out_ch.next_pc),
        .branch_taken   (out_ch.branch_taken),
        .divide_by_zero (out_ch.divide_by_zero)
    );

endmodule
